>>> sv/synth_voice_oscillator_envelope_macros.svh
// Assertion macros for the synth voice block checker.
// Depends on nothing; the checker module includes it.
`ifndef SYNTH_VOICE_OSCILLATOR_ENVELOPE_MACROS_SVH
`define SYNTH_VOICE_OSCILLATOR_ENVELOPE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SVOE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svoe check failed");

// Next-cycle implication, disabled during reset.
`define SVOE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svoe check failed");

`endif

>>> sv/svoe_pkg.sv
// Package for the synth voice block: types, constants and the constant tables.
// Used by every RTL file of the block; depends on nothing.
`timescale 1ns / 1ps

package svoe_pkg;

  localparam int SAMPLE_RATE      = 48000;
  localparam int PHASE_BITS       = 24;
  localparam int BEND_TABLE_DEPTH = 64;

  localparam int BIDX_W = $clog2(BEND_TABLE_DEPTH + 1);
  localparam int BPOS_W = 14 + BIDX_W;

  localparam logic [63:0] HALF_RATE = 64'(SAMPLE_RATE / 2);
  localparam logic [63:0] BEND_DEN  = 64'(6 * BEND_TABLE_DEPTH);

  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [24:0] ENV_ONE   = 25'd16777216;
  localparam logic [23:0] ENV_FLOOR = 24'd1678;
  localparam logic [15:0] PW_MIN    = 16'd3277;
  localparam logic [15:0] PW_MAX    = 16'd62259;
  localparam logic [15:0] LFO_MIN   = 16'd8192;
  localparam logic [15:0] LFO_MAX   = 16'd32768;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_NOTE_ON  = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_BEND     = 3'd3,
    OP_LFO      = 3'd4,
    OP_CHAN_AT  = 3'd5,
    OP_POLY_AT  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    CFG_PULSE_WIDTH  = 2'd0,
    CFG_SUB_LEVEL    = 2'd1,
    CFG_ATTACK_COEF  = 2'd2,
    CFG_RELEASE_COEF = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_FETCH,
    ST_ENV_MUL,
    ST_ENV_WB,
    ST_DIV,
    ST_OSC,
    ST_BEND_MUL,
    ST_BEND_WB,
    ST_UPD_MUL1,
    ST_UPD_T,
    ST_UPD_MUL2,
    ST_UPD_WB,
    ST_DONE
  } st_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         channel;
    logic [6:0]         note;
    logic [15:0]        velocity;
    logic signed [13:0] bend;
    logic [15:0]        lfo_multiplier;
    logic [15:0]        pressure;
  } item_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic [15:0] sub_level;
    logic [23:0] attack_coef;
    logic [23:0] release_coef;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] source_sample;
    logic [16:0]        gain;
    logic               voice_active;
    logic               off_matched;
  } res_t;

  typedef logic [31:0] note_rom_t [128];
  typedef logic [31:0] bend_rom_t [BEND_TABLE_DEPTH + 1];

  // Unsigned 64-bit quotient by shift and subtract; used only to build tables.
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^y for y in Q30 (0 <= y < 1), by a power series up to the 16th-order term; result in Q30.
  function automatic logic [63:0] exp2_q30(logic [63:0] y);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    x    = (y * LN2_Q30) >> 30;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = udiv64((term * x) >> 30, 64'(n));
      sum  = sum + term;
    end
    return sum;
  endfunction

  // Phase increment of each MIDI note, saturated to 32 bits.
  function automatic note_rom_t build_note_rom();
    note_rom_t   rom;
    logic [63:0] val;
    logic [63:0] q;
    int          m;
    int          oct;
    int          k;
    int          s;
    for (int n = 0; n < 128; n++) begin
      m   = n + 3;
      oct = int'(udiv64(64'(m), 64'd12));
      k   = m - 12 * oct;
      val = 64'd440 * exp2_q30(udiv64(64'(k) << 30, 64'd12));
      s   = oct + PHASE_BITS - 36;
      if (s >= 0) begin
        q = udiv64((val << s) + HALF_RATE, 64'(SAMPLE_RATE));
      end else begin
        q = udiv64((val + (64'(SAMPLE_RATE) << (-s - 1))) >> (-s), 64'(SAMPLE_RATE));
      end
      rom[n] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    return rom;
  endfunction

  // Q30 samples of 2^(bend/49152) over bend -8192..8192.
  function automatic bend_rom_t build_bend_rom();
    bend_rom_t   rom;
    logic [63:0] mag;
    logic [63:0] v;
    logic [63:0] r;
    logic        neg;
    for (int i = 0; i <= BEND_TABLE_DEPTH; i++) begin
      neg = (2 * i) < BEND_TABLE_DEPTH;
      mag = neg ? 64'(BEND_TABLE_DEPTH - 2 * i) : 64'(2 * i - BEND_TABLE_DEPTH);
      v   = exp2_q30(udiv64(mag << 30, BEND_DEN));
      r   = udiv64(64'd1 << 60, v);
      rom[i] = neg ? r[31:0] : v[31:0];
    end
    return rom;
  endfunction

  localparam note_rom_t NOTE_ROM = build_note_rom();
  localparam bend_rom_t BEND_ROM = build_bend_rom();

endpackage

>>> sv/svoe_front.sv
// Front end of the synth voice: accepts input words, decodes the op and
// holds them in a two-entry queue for the back end. Depends on svoe_pkg.
`timescale 1ns / 1ps

module svoe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [79:0]   in_tdata,
  input  logic [2:0]    in_tuser,
  output logic          item_valid,
  output svoe_pkg::item_t item,
  input  logic          item_pop
);
  import svoe_pkg::*;

  item_t       q_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  logic        pop;
  item_t       dec;

  // Unpack and classify the incoming word.
  always_comb begin
    dec.op             = op_t'(in_tuser);
    dec.channel        = in_tdata[3:0];
    dec.note           = in_tdata[10:4];
    dec.velocity       = in_tdata[26:11];
    dec.bend           = in_tdata[40:27];
    dec.lfo_multiplier = in_tdata[56:41];
    dec.pressure       = in_tdata[72:57];
  end

  assign in_tready  = (count_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign item_valid = (count_r != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = q_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= dec;
  end

endmodule

>>> sv/svoe_back.sv
// Back end of the synth voice: a sequencer with one shared multiplier and a
// two-bit-per-cycle divider, plus the result register. Depends on svoe_pkg.
`timescale 1ns / 1ps

module svoe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  svoe_pkg::cfg_t  cfg,
  input  logic            item_valid,
  input  svoe_pkg::item_t item,
  output logic            item_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output svoe_pkg::res_t  res
);
  import svoe_pkg::*;

  localparam int PB = PHASE_BITS;

  st_t                state_r, state_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  item_t              item_r, item_nxt;
  logic [64:0]        prod_r, prod_nxt;
  logic [23:0]        env_level_r, env_level_nxt;
  logic               env_rising_r, env_rising_nxt;
  logic               sounding_r, sounding_nxt;
  logic [3:0]         held_channel_r, held_channel_nxt;
  logic [6:0]         held_note_r, held_note_nxt;
  logic [15:0]        held_velocity_r, held_velocity_nxt;
  logic [31:0]        base_inc_r, base_inc_nxt;
  logic [17:0]        bend_factor_r, bend_factor_nxt;
  logic [15:0]        lfo_factor_r, lfo_factor_nxt;
  logic [15:0]        chan_pr_r, chan_pr_nxt;
  logic [15:0]        poly_pr_r, poly_pr_nxt;
  logic [31:0]        phase_inc_r, phase_inc_nxt;
  logic [PB-1:0]      main_phase_r, main_phase_nxt;
  logic [PB-1:0]      sub_phase_r, sub_phase_nxt;
  logic [33:0]        t_r, t_nxt;
  logic [PB:0]        rem_r, rem_nxt;
  logic [PB:0]        den_r, den_nxt;
  logic [15:0]        quo_r, quo_nxt;
  logic               sel_lo_r, sel_lo_nxt;
  logic               sub_neg_r, sub_neg_nxt;
  logic [16:0]        gain_r, gain_nxt;
  logic signed [16:0] sample_r, sample_nxt;
  logic               matched_r, matched_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;

  logic [39:0]        mul_a;
  logic [24:0]        mul_b;
  logic [64:0]        mul_p;
  logic               prod_ld;

  logic [PB:0]        full_c;
  logic [15:0]        pwq;
  logic [PB-1:0]      pw_c;
  logic [24:0]        env_dec;
  logic [23:0]        env_new;
  logic [PB-1:0]      mp;
  logic [PB-1:0]      sp;
  logic [PB+1:0]      r1, r2;
  logic               b1, b2;
  logic [15:0]        at_max;
  logic [16:0]        gmul;
  logic [64:0]        g_round;
  logic [13:0]        boff;
  logic [BPOS_W-1:0]  bpos;
  logic [BIDX_W-1:0]  bidx;
  logic [BIDX_W-1:0]  bidx1;
  logic [31:0]        blo, bhi;
  logic [31:0]        bv;
  logic [31:0]        bf_round;
  logic [64:0]        t_round;
  logic [64:0]        inc_round;
  logic signed [18:0] osc;
  logic signed [18:0] subv;
  logic signed [18:0] sum;

  assign mul_p      = 65'(mul_a) * 65'(mul_b);
  assign out_tvalid = out_valid_r;
  assign res        = res_r;
  assign item_pop   = (state_r == ST_FETCH) && item_valid;

  // Sequencer: next state, datapath updates and multiplier operands.
  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    item_nxt          = item_r;
    env_level_nxt     = env_level_r;
    env_rising_nxt    = env_rising_r;
    sounding_nxt      = sounding_r;
    held_channel_nxt  = held_channel_r;
    held_note_nxt     = held_note_r;
    held_velocity_nxt = held_velocity_r;
    base_inc_nxt      = base_inc_r;
    bend_factor_nxt   = bend_factor_r;
    lfo_factor_nxt    = lfo_factor_r;
    chan_pr_nxt       = chan_pr_r;
    poly_pr_nxt       = poly_pr_r;
    phase_inc_nxt     = phase_inc_r;
    main_phase_nxt    = main_phase_r;
    sub_phase_nxt     = sub_phase_r;
    t_nxt             = t_r;
    rem_nxt           = rem_r;
    den_nxt           = den_r;
    quo_nxt           = quo_r;
    sel_lo_nxt        = sel_lo_r;
    sub_neg_nxt       = sub_neg_r;
    gain_nxt          = gain_r;
    sample_nxt        = sample_r;
    matched_nxt       = matched_r;
    res_nxt           = res_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    mul_a             = '0;
    mul_b             = '0;
    prod_ld           = 1'b0;

    full_c  = (PB + 1)'(1) << PB;
    pwq     = (cfg.pulse_width < PW_MIN) ? PW_MIN :
              ((cfg.pulse_width > PW_MAX) ? PW_MAX : cfg.pulse_width);
    pw_c    = PB'(pwq) << (PB - 16);
    env_dec = 25'((prod_r + 65'h0FF_FFFF) >> 24);
    env_new = env_rising_r ? (env_level_r + prod_r[47:24]) : (env_level_r - env_dec[23:0]);
    mp      = main_phase_r + phase_inc_r[PB-1:0];
    sp      = sub_phase_r + PB'(phase_inc_r >> 1);

    // Two restoring division steps per cycle.
    r1 = {rem_r, 1'b0};
    b1 = (r1 >= (PB + 2)'(den_r));
    if (b1) r1 = r1 - (PB + 2)'(den_r);
    r2 = {r1[PB:0], 1'b0};
    b2 = (r2 >= (PB + 2)'(den_r));
    if (b2) r2 = r2 - (PB + 2)'(den_r);

    at_max  = (chan_pr_r > poly_pr_r) ? chan_pr_r : poly_pr_r;
    gmul    = 17'd65536 + 17'(at_max >> 2);
    g_round = prod_r + (65'd1 << 39);

    boff     = item_r.bend ^ 14'h2000;
    bpos     = BPOS_W'(boff) * BPOS_W'(BEND_TABLE_DEPTH);
    bidx     = bpos[BPOS_W-1:14];
    bidx1    = bidx + 1'b1;
    blo      = BEND_ROM[bidx];
    bhi      = BEND_ROM[bidx1];
    bv       = blo + prod_r[45:14];
    bf_round = (bv + 32'd8192) >> 14;

    t_round   = (prod_r + 65'd32768) >> 16;
    inc_round = (prod_r + 65'd8192) >> 14;

    osc  = sel_lo_r ? (19'sd0 + $signed({3'b000, quo_r}) - 19'sd32768)
                    : (19'sd32768 - $signed({3'b000, quo_r}));
    subv = $signed(19'((17'(cfg.sub_level) + 17'd1) >> 1));
    sum  = sub_neg_r ? (osc - subv) : (osc + subv);

    case (state_r)
      ST_FETCH: begin
        if (item_valid) begin
          item_nxt    = item;
          sample_nxt  = '0;
          gain_nxt    = '0;
          matched_nxt = 1'b0;
          state_nxt   = ST_DONE;
          case (item.op)
            OP_TICK: state_nxt = ST_ENV_MUL;
            OP_NOTE_ON: begin
              sounding_nxt      = 1'b1;
              held_velocity_nxt = item.velocity;
              held_channel_nxt  = item.channel;
              held_note_nxt     = item.note;
              base_inc_nxt      = NOTE_ROM[item.note];
              env_level_nxt     = '0;
              env_rising_nxt    = 1'b1;
              main_phase_nxt    = '0;
              sub_phase_nxt     = '0;
              state_nxt         = ST_UPD_MUL1;
            end
            OP_NOTE_OFF: begin
              if (sounding_r && held_channel_r == item.channel &&
                  held_note_r == item.note) begin
                env_rising_nxt = 1'b0;
                matched_nxt    = 1'b1;
              end
            end
            OP_BEND: state_nxt = ST_BEND_MUL;
            OP_LFO: begin
              lfo_factor_nxt = (item.lfo_multiplier < LFO_MIN) ? LFO_MIN :
                               ((item.lfo_multiplier > LFO_MAX) ? LFO_MAX
                                                                : item.lfo_multiplier);
              state_nxt = ST_UPD_MUL1;
            end
            OP_CHAN_AT: chan_pr_nxt = item.pressure;
            OP_POLY_AT: poly_pr_nxt = item.pressure;
            default: ;
          endcase
        end
      end
      ST_ENV_MUL: begin
        if (!sounding_r) begin
          state_nxt = ST_DONE;
        end else begin
          prod_ld   = 1'b1;
          mul_a     = env_rising_r ? 40'(ENV_ONE - 25'(env_level_r)) : 40'(env_level_r);
          mul_b     = env_rising_r ? 25'(cfg.attack_coef) : 25'(cfg.release_coef);
          state_nxt = ST_ENV_WB;
        end
      end
      ST_ENV_WB: begin
        env_level_nxt = env_new;
        if (!env_rising_r && env_new < ENV_FLOOR) begin
          // Release has decayed away: the voice goes quiet.
          sounding_nxt      = 1'b0;
          base_inc_nxt      = '0;
          phase_inc_nxt     = '0;
          held_velocity_nxt = '0;
          state_nxt         = ST_DONE;
        end else begin
          main_phase_nxt = mp;
          sub_phase_nxt  = sp;
          sub_neg_nxt    = sp[PB-1];
          if (mp < pw_c) begin
            sel_lo_nxt = 1'b1;
            rem_nxt    = (PB + 1)'(mp);
            den_nxt    = (PB + 1)'(pw_c);
          end else begin
            sel_lo_nxt = 1'b0;
            rem_nxt    = (PB + 1)'(mp - pw_c);
            den_nxt    = full_c - (PB + 1)'(pw_c);
          end
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = r2[PB:0];
        quo_nxt = {quo_r[13:0], b1, b2};
        cnt_nxt = cnt_r + 3'd1;
        // The gain products share the divider's cycles.
        if (cnt_r == 3'd0) begin
          prod_ld = 1'b1;
          mul_a   = 40'(env_level_r);
          mul_b   = 25'(held_velocity_r);
        end else if (cnt_r == 3'd1) begin
          prod_ld = 1'b1;
          mul_a   = prod_r[39:0];
          mul_b   = 25'(gmul);
        end else if (cnt_r == 3'd2) begin
          gain_nxt = g_round[56:40];
        end
        if (cnt_r == 3'd7) state_nxt = ST_OSC;
      end
      ST_OSC: begin
        if (sum > 19'sd65535) begin
          sample_nxt = 17'sd65535;
        end else if (sum < -19'sd65536) begin
          sample_nxt = -17'sd65536;
        end else begin
          sample_nxt = sum[16:0];
        end
        state_nxt = ST_DONE;
      end
      ST_BEND_MUL: begin
        prod_ld   = 1'b1;
        mul_a     = 40'(bhi - blo);
        mul_b     = 25'(bpos[13:0]);
        state_nxt = ST_BEND_WB;
      end
      ST_BEND_WB: begin
        bend_factor_nxt = bf_round[17:0];
        state_nxt       = ST_UPD_MUL1;
      end
      ST_UPD_MUL1: begin
        prod_ld   = 1'b1;
        mul_a     = 40'(base_inc_r);
        mul_b     = 25'(bend_factor_r);
        state_nxt = ST_UPD_T;
      end
      ST_UPD_T: begin
        t_nxt     = t_round[33:0];
        state_nxt = ST_UPD_MUL2;
      end
      ST_UPD_MUL2: begin
        prod_ld   = 1'b1;
        mul_a     = 40'(t_r);
        mul_b     = 25'(lfo_factor_r);
        state_nxt = ST_UPD_WB;
      end
      ST_UPD_WB: begin
        phase_inc_nxt = (inc_round[64:32] != '0) ? 32'hFFFF_FFFF : inc_round[31:0];
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // Load the result register once it is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt         = 1'b1;
          res_nxt.source_sample = sample_r;
          res_nxt.gain          = gain_r;
          res_nxt.voice_active  = sounding_r;
          res_nxt.off_matched   = matched_r;
          state_nxt             = ST_FETCH;
        end
      end
      default: state_nxt = ST_FETCH;
    endcase

    prod_nxt = prod_ld ? mul_p : prod_r;
  end

  // Control and voice state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_FETCH;
      out_valid_r     <= 1'b0;
      env_level_r     <= '0;
      env_rising_r    <= 1'b0;
      sounding_r      <= 1'b0;
      held_channel_r  <= '0;
      held_note_r     <= '0;
      held_velocity_r <= '0;
      base_inc_r      <= '0;
      bend_factor_r   <= 18'd65536;
      lfo_factor_r    <= 16'd16384;
      chan_pr_r       <= '0;
      poly_pr_r       <= '0;
      phase_inc_r     <= '0;
      main_phase_r    <= '0;
      sub_phase_r     <= '0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      env_level_r     <= env_level_nxt;
      env_rising_r    <= env_rising_nxt;
      sounding_r      <= sounding_nxt;
      held_channel_r  <= held_channel_nxt;
      held_note_r     <= held_note_nxt;
      held_velocity_r <= held_velocity_nxt;
      base_inc_r      <= base_inc_nxt;
      bend_factor_r   <= bend_factor_nxt;
      lfo_factor_r    <= lfo_factor_nxt;
      chan_pr_r       <= chan_pr_nxt;
      poly_pr_r       <= poly_pr_nxt;
      phase_inc_r     <= phase_inc_nxt;
      main_phase_r    <= main_phase_nxt;
      sub_phase_r     <= sub_phase_nxt;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    item_r    <= item_nxt;
    prod_r    <= prod_nxt;
    t_r       <= t_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    quo_r     <= quo_nxt;
    sel_lo_r  <= sel_lo_nxt;
    sub_neg_r <= sub_neg_nxt;
    gain_r    <= gain_nxt;
    sample_r  <= sample_nxt;
    matched_r <= matched_nxt;
    res_r     <= res_nxt;
  end

endmodule

>>> sv/synth_voice_oscillator_envelope.sv
// Top level of the synth voice: configuration registers, front queue and
// back sequencer. Depends on svoe_pkg, svoe_front and svoe_back.
//
// Usage: event words enter on in_* (op in in_tuser), one result word per
// event leaves on out_*. Registers must be written on cfg_* only while the voice
// is idle; the block does not enforce this, and cfg_ready is always high.
// Flow: after the front queue, the back sequencer goes straight to its result
// for note off, aftertouch and unused ops, and recomputes the phase increment
// for note on and LFO, after a bend table lookup for bend. A sounding tick steps
// the envelope and, unless the voice goes quiet, runs the divider for the
// triangle slope (16 quotient bits, two per cycle) beside the shared multiplier.
// The queue holds two words, so input is taken while the back end works; a
// finished result waits in the output register while the next word proceeds.
// If the receiver stalls, the sequencer holds its last result step until the
// output register frees and the queue then fills and drops in_tready.
// Reset (synchronous, rst_n low) empties the queue and returns the voice to
// silence with registers at their defaults.
`timescale 1ns / 1ps

module synth_voice_oscillator_envelope (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // channel[3:0], note[10:4], velocity[26:11], bend[40:27],
  // lfo_multiplier[56:41], pressure[72:57], zero above
  input  logic [79:0] in_tdata,
  // op[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // source_sample[16:0], gain[33:17], voice_active[34], off_matched[35], zero above
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import svoe_pkg::*;

  cfg_t  cfg_r;
  logic  item_valid;
  item_t item;
  logic  item_pop;
  res_t  res;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_width  <= 16'd32768;
      cfg_r.sub_level    <= 16'd0;
      cfg_r.attack_coef  <= 24'hFF_FFFF;
      cfg_r.release_coef <= 24'hFF_FFFF;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PULSE_WIDTH:  cfg_r.pulse_width  <= cfg_data[15:0];
        CFG_SUB_LEVEL:    cfg_r.sub_level    <= cfg_data[15:0];
        CFG_ATTACK_COEF:  cfg_r.attack_coef  <= cfg_data;
        CFG_RELEASE_COEF: cfg_r.release_coef <= cfg_data;
        default: ;
      endcase
    end
  end

  svoe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  svoe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  // Pack the result word.
  assign out_tdata = {4'b0000, res.off_matched, res.voice_active, res.gain,
                      res.source_sample};

endmodule

>>> sv/svoe_checker.sv
// Port-level checker for the synth voice, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "synth_voice_oscillator_envelope_macros.svh"

module svoe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result word holds.
  `SVOE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // A matched note off always leaves the voice sounding.
  `SVOE_ASSERT_NOW(a_match_active, out_tvalid && out_tdata[35], out_tdata[34])
  // Gain is only given by a sounding voice.
  `SVOE_ASSERT_NOW(a_gain_active, out_tvalid && (out_tdata[33:17] != 17'd0), out_tdata[34])
  // Gain never exceeds full envelope, velocity and aftertouch boost.
  `SVOE_ASSERT_NOW(a_gain_max, out_tvalid, out_tdata[33:17] <= 17'd81920)

endmodule

bind synth_voice_oscillator_envelope svoe_checker u_svoe_checker (.*);

>>> bench/tb.sv
// Self-checking bench for the synth voice oscillator and envelope block.
// It depends on svoe_pkg for the op and register codes, and on the block's top level.
`timescale 1ns / 1ps

module tb;
  import svoe_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int         WATCHDOG  = 5000;
  localparam int         SETTLE    = 30;
  localparam int         RATE      = 48000;
  localparam int         PBITS     = 24;
  localparam int         BDEPTH    = 64;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [15:0] velocity;
    logic [13:0] bend;
    logic [15:0] lfo;
    logic [15:0] pressure;
  } voice_event_t;

  typedef struct packed {
    logic [16:0] sample;
    logic [16:0] gain;
    logic        active;
    logic        matched;
  } voice_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  synth_voice_oscillator_envelope dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  voice_event_t pending_events[$];
  voice_word_t  expected_words[$];
  int           failures = 0;
  bit           quiet = 1'b0;

  // Mirror of the voice: tables, registers and state.
  logic [31:0] pitch_table [128];
  logic [63:0] bend_curve [BDEPTH + 1];
  logic [15:0] m_pulse_width, m_sub_level;
  logic [23:0] m_attack, m_release, m_env;
  logic [23:0] m_main_phase, m_sub_phase;
  logic        m_rising, m_sounding;
  logic [3:0]  m_channel;
  logic [6:0]  m_note;
  logic [15:0] m_velocity, m_lfo, m_chan_at, m_poly_at;
  logic [31:0] m_base_inc, m_phase_inc;
  logic [17:0] m_bend_factor;

  // Power series for 2^y, y in Q30 with 0 <= y < 1.
  function automatic logic [63:0] pow2_frac(logic [63:0] y);
    logic [63:0] x, acc, term;
    x    = (y * 64'd744261118) >> 30;
    acc  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * x) >> 30) / 64'(n);
      acc  = acc + term;
    end
    return acc;
  endfunction

  task automatic fill_tables();
    logic [63:0] val, q, den, mag, v;
    int          m, s;
    bit          neg;
    for (int n = 0; n < 128; n++) begin
      m   = n + 3;
      val = 64'd440 * pow2_frac((64'(m % 12) << 30) / 12);
      s   = m / 12 + PBITS - 36;
      if (s >= 0) begin
        q = ((val << s) + 64'(RATE / 2)) / 64'(RATE);
      end else begin
        den = 64'(RATE) << (-s);
        q   = (val + den / 2) / den;
      end
      pitch_table[n] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    for (int i = 0; i <= BDEPTH; i++) begin
      neg = (2 * i) < BDEPTH;
      mag = neg ? 64'(BDEPTH - 2 * i) : 64'(2 * i - BDEPTH);
      v   = pow2_frac((mag << 30) / (6 * BDEPTH));
      bend_curve[i] = neg ? ((64'd1 << 60) / v) : v;
    end
  endtask

  task automatic reset_voice();
    m_pulse_width = 16'd32768; m_sub_level = 0;
    m_attack = 24'hFFFFFF; m_release = 24'hFFFFFF;
    m_env = 0; m_main_phase = 0; m_sub_phase = 0;
    m_rising = 0; m_sounding = 0;
    m_channel = 0; m_note = 0; m_velocity = 0;
    m_base_inc = 0; m_phase_inc = 0;
    m_bend_factor = 18'd65536; m_lfo = 16'd16384;
    m_chan_at = 0; m_poly_at = 0;
  endtask

  task automatic retune();
    logic [63:0] t;
    t = (64'(m_base_inc) * 64'(m_bend_factor) + 64'd32768) >> 16;
    t = (t * 64'(m_lfo) + 64'd8192) >> 14;
    m_phase_inc = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endtask

  // Works out the result word for one event and advances the mirrored state.
  task automatic voice_step(input voice_event_t ev);
    voice_word_t w;
    logic [63:0] pw, p, full, pos, frac, lo, hi, v, bend_off;
    logic [15:0] pwq, at;
    longint      osc, sub, smp;
    w    = '0;
    smp  = 0;
    full = 64'd1 << PBITS;
    case (ev.op)
      OP_TICK: begin
        if (m_sounding) begin
          if (m_rising)
            m_env = m_env + 24'(((64'd16777216 - 64'(m_env)) * 64'(m_attack)) >> 24);
          else
            m_env = m_env - 24'((64'(m_env) * 64'(m_release) + 64'hFFFFFF) >> 24);
          if (!m_rising && m_env < 24'd1678) begin
            m_sounding = 0; m_base_inc = 0; m_phase_inc = 0; m_velocity = 0;
          end else begin
            pwq = (m_pulse_width < 16'd3277) ? 16'd3277 :
                  (m_pulse_width > 16'd62259) ? 16'd62259 : m_pulse_width;
            at  = (m_chan_at > m_poly_at) ? m_chan_at : m_poly_at;
            m_main_phase = 24'(64'(m_main_phase) + 64'(m_phase_inc));
            m_sub_phase  = 24'(64'(m_sub_phase) + 64'(m_phase_inc >> 1));
            pw = 64'(pwq) << (PBITS - 16);
            p  = 64'(m_main_phase);
            if (p < pw) osc = longint'((p << 16) / pw) - 32768;
            else osc = 32768 - longint'(((p - pw) << 16) / (full - pw));
            sub = longint'((32'(m_sub_level) + 1) >> 1);
            if (m_sub_phase[PBITS-1]) sub = -sub;
            smp = osc + sub;
            if (smp > 65535) smp = 65535;
            if (smp < -65536) smp = -65536;
            w.gain = 17'((64'(m_env) * 64'(m_velocity) * (64'd65536 + 64'(at >> 2))
                          + (64'd1 << 39)) >> 40);
          end
        end
      end
      OP_NOTE_ON: begin
        m_sounding = 1; m_velocity = ev.velocity;
        m_channel = ev.channel; m_note = ev.note;
        m_base_inc = pitch_table[ev.note];
        retune();
        m_env = 0; m_rising = 1; m_main_phase = 0; m_sub_phase = 0;
      end
      OP_NOTE_OFF: begin
        if (m_sounding && m_channel == ev.channel && m_note == ev.note) begin
          m_rising = 0; w.matched = 1;
        end
      end
      OP_BEND: begin
        bend_off = 64'(ev.bend ^ 14'h2000);
        pos  = bend_off * BDEPTH;
        frac = pos & 64'd16383;
        lo   = bend_curve[pos >> 14];
        hi   = bend_curve[(pos >> 14) + 1];
        v    = lo + (((hi - lo) * frac) >> 14);
        m_bend_factor = 18'((v + 64'd8192) >> 14);
        retune();
      end
      OP_LFO: begin
        m_lfo = (ev.lfo < 16'd8192) ? 16'd8192 : (ev.lfo > 16'd32768) ? 16'd32768 : ev.lfo;
        retune();
      end
      OP_CHAN_AT: m_chan_at = ev.pressure;
      OP_POLY_AT: m_poly_at = ev.pressure;
      default: ;
    endcase
    w.sample = 17'(smp);
    w.active = m_sounding;
    expected_words.push_back(w);
  endtask

  // Input driver: presents queued events, with random bursts of idling.
  int in_gap = 0;
  always @(posedge clk) begin
    voice_event_t nxt;
    bit           free;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      free = !in_tvalid;
      if (in_tvalid && in_tready) begin
        voice_step(pending_events.pop_front());
        free = 1'b1;
      end
      if (free && in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (free && !quiet && $urandom_range(0, 9) == 0) begin
        in_gap    <= $urandom_range(0, 10);
        in_tvalid <= 1'b0;
      end else if (free && pending_events.size() != 0) begin
        nxt       = pending_events[0];
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.op;
        in_tdata  <= {7'd0, nxt.pressure, nxt.lfo, nxt.bend, nxt.velocity, nxt.note,
                      nxt.channel};
      end else if (free) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each word with the oldest expectation.
  int out_gap = 0;
  always @(posedge clk) begin
    voice_word_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[16:0], out_tdata[33:17], out_tdata[34], out_tdata[35]};
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (got.sample !== want.sample) begin
            $error("source_sample: expected %0d, got %0d", $signed(want.sample),
                   $signed(got.sample));
            failures++;
          end
          if (got.gain !== want.gain) begin
            $error("gain: expected %0d, got %0d", want.gain, got.gain);
            failures++;
          end
          if (got.active !== want.active) begin
            $error("voice_active: expected %0b, got %0b", want.active, got.active);
            failures++;
          end
          if (got.matched !== want.matched) begin
            $error("off_matched: expected %0b, got %0b", want.matched, got.matched);
            failures++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap    <= $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  int stuck = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else if (stuck >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PULSE_WIDTH:  m_pulse_width = val[15:0];
      CFG_SUB_LEVEL:    m_sub_level   = val[15:0];
      CFG_ATTACK_COEF:  m_attack      = val;
      CFG_RELEASE_COEF: m_release     = val;
      default: ;
    endcase
  endtask

  task automatic set_voicing(input logic [15:0] pw, input logic [15:0] sl,
                             input logic [23:0] att, input logic [23:0] rel);
    write_reg(CFG_PULSE_WIDTH, 24'(pw));
    write_reg(CFG_SUB_LEVEL, 24'(sl));
    write_reg(CFG_ATTACK_COEF, att);
    write_reg(CFG_RELEASE_COEF, rel);
  endtask

  // Holds the sender back until every expected word has come, then lets the block settle.
  task automatic drain();
    @(posedge clk);
    while (pending_events.size() != 0 || in_tvalid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic voice_event_t any_event();
    voice_event_t ev;
    ev = 76'({$urandom, $urandom, $urandom});
    return ev;
  endfunction

  task automatic push(input logic [2:0] op, input logic [3:0] ch, input logic [6:0] nt);
    voice_event_t ev;
    ev = any_event();
    ev.op = op; ev.channel = ch; ev.note = nt;
    pending_events.push_back(ev);
  endtask

  task automatic push_full(input voice_event_t ev);
    pending_events.push_back(ev);
  endtask

  // Mostly note on, ticks, note off and ticks, with modulation mixed in; the rest is noise.
  task automatic random_phase(input int count);
    int          n, k;
    logic [3:0]  ch;
    logic [6:0]  nt;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 7) begin
        ch = 4'($urandom);
        nt = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(30, 100));
        push(OP_NOTE_ON, ch, nt);
        k = $urandom_range(1, 40);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 7) == 0) push(3'($urandom_range(3, 6)), 0, 0);
          else push(OP_TICK, 0, 0);
        end
        if ($urandom_range(0, 5) == 0) push(OP_NOTE_OFF, ch + 4'd1, nt);
        push(OP_NOTE_OFF, ch, nt);
        k = $urandom_range(1, 40);
        for (int i = 0; i < k; i++) push(OP_TICK, 0, 0);
        n = n + 5 + 2 * k;
      end else begin
        push(3'($urandom), 4'($urandom), 7'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    voice_event_t ev;
    fill_tables();
    reset_voice();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events at the register defaults.
    push(OP_BEND, 0, 0);
    ev = any_event(); ev.op = OP_BEND; ev.bend = 14'h2000; push_full(ev);
    ev = any_event(); ev.op = OP_NOTE_ON; ev.channel = 0; ev.note = 0; ev.velocity = 0;
    push_full(ev);
    push(OP_TICK, 0, 0);
    ev = any_event(); ev.op = OP_BEND; ev.bend = 14'h1FFF; push_full(ev);
    ev = any_event(); ev.op = OP_BEND; ev.bend = 14'h0; push_full(ev);
    ev = any_event(); ev.op = OP_LFO; ev.lfo = 16'h0; push_full(ev);
    ev = any_event(); ev.op = OP_LFO; ev.lfo = 16'hFFFF; push_full(ev);
    ev = any_event(); ev.op = OP_LFO; ev.lfo = 16'd16384; push_full(ev);
    ev = any_event(); ev.op = OP_CHAN_AT; ev.pressure = 16'hFFFF; push_full(ev);
    ev = any_event(); ev.op = OP_POLY_AT; ev.pressure = 16'h0; push_full(ev);
    ev = any_event(); ev.op = OP_NOTE_ON; ev.channel = 15; ev.note = 127;
    ev.velocity = 16'hFFFF; push_full(ev);
    push(OP_TICK, 0, 0);
    push(OP_NOTE_ON, 15, 127);
    push(OP_TICK, 0, 0);
    push(OP_NOTE_OFF, 14, 127);
    push(OP_NOTE_OFF, 15, 126);
    push(OP_UNUSED, 15, 127);
    push(OP_NOTE_OFF, 15, 127);
    push(OP_TICK, 0, 0);
    push(OP_TICK, 0, 0);
    push(OP_NOTE_OFF, 15, 127);
    push(OP_POLY_AT, 0, 0);
    drain();

    // Random phases over a spread of voicings, extremes first.
    set_voicing(16'd3277, 16'hFFFF, 24'h100000, 24'h080000);
    random_phase(250);
    drain();
    set_voicing(16'd62259, 16'd0, 24'hFFFFFF, 24'h0);
    random_phase(250);
    drain();
    set_voicing(16'd0, 16'd1, 24'h0, 24'hFFFFFF);
    random_phase(250);
    drain();
    set_voicing(16'hFFFF, 16'($urandom), 24'($urandom),
                24'($urandom_range(24'h040000, 24'hFFFFFF)));
    random_phase(250);
    drain();
    set_voicing(16'($urandom), 16'($urandom), 24'($urandom),
                24'($urandom_range(24'h040000, 24'hFFFFFF)));
    quiet = 1'b1;
    random_phase(250);
    drain();

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> synth_voice_oscillator_envelope.f
+incdir+sv
sv/svoe_pkg.sv
sv/svoe_front.sv
sv/svoe_back.sv
sv/synth_voice_oscillator_envelope.sv
sv/svoe_checker.sv
bench/tb.sv
